/* rtl/three_lane_min_cost_path_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the three-lane minimum cost path unit
// Concurrent checks, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef THREE_LANE_MIN_COST_PATH_UNIT_DEFINES_SVH
`define THREE_LANE_MIN_COST_PATH_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TLMC_ASSERT_NOW(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

`define TLMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TLMC_ASSERT_NOW(label, clk, rst_n, cond)

`define TLMC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/tlmc_pkg.sv */
// ----------------------------------------------------------------------------
// tlmc_pkg
// Shared constants, row phase codes and the front status type of the path unit.
// ----------------------------------------------------------------------------
package tlmc_pkg;

    localparam int ACC_BITS            = 40;
    localparam int COST_BITS_DEFAULT   = 16;
    localparam int ROW_QUEUE_DEPTH_DEF = 2;
    localparam int RES_QUEUE_DEPTH_DEF = 2;

    localparam int PHASE_BITS = 2;
    localparam logic [PHASE_BITS-1:0] PH_FIRST  = 2'd0;
    localparam logic [PHASE_BITS-1:0] PH_SECOND = 2'd1;
    localparam logic [PHASE_BITS-1:0] PH_LATER  = 2'd2;

    typedef struct packed {
        logic                  accept;
        logic                  last;
        logic [PHASE_BITS-1:0] phase;
    } t_front_stat;

endpackage

/* rtl/tlmc_queue.sv */
// ----------------------------------------------------------------------------
// tlmc_queue
// Small synchronous FIFO; push/full on the write side, pop/empty on the read.
// ----------------------------------------------------------------------------
module tlmc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({push_ok, pop_ok})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/tlmc_front.sv */
// ----------------------------------------------------------------------------
// tlmc_front
// Accept rows, tag each with its row phase within the graph, pack for the queue.
// ----------------------------------------------------------------------------
module tlmc_front #(
    parameter int COST_BITS = tlmc_pkg::COST_BITS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    input  logic                                 i_queue_full,
    input  logic signed [COST_BITS-1:0]          i_cost_left,
    input  logic signed [COST_BITS-1:0]          i_cost_mid,
    input  logic signed [COST_BITS-1:0]          i_cost_right,
    input  logic                                 i_last_row,
    output logic                                 o_queue_push,
    output logic [3*COST_BITS+tlmc_pkg::PHASE_BITS:0] o_item,
    output tlmc_pkg::t_front_stat                o_stat
);
    import tlmc_pkg::*;

    logic [PHASE_BITS-1:0] r_phase, n_phase;
    logic                  accept;

    assign accept       = i_push && !i_queue_full;
    assign o_queue_push = accept;
    assign o_item       = {r_phase, i_last_row, i_cost_left, i_cost_mid, i_cost_right};

    assign o_stat.accept = accept;
    assign o_stat.last   = i_last_row;
    assign o_stat.phase  = r_phase;

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            priority if (i_last_row) begin
                n_phase = PH_FIRST;
            end else if (r_phase == PH_FIRST) begin
                n_phase = PH_SECOND;
            end else begin
                n_phase = PH_LATER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule

/* rtl/tlmc_back.sv */
// ----------------------------------------------------------------------------
// tlmc_back
// Row recurrence: update the three lane best costs, emit mid on a last row.
// ----------------------------------------------------------------------------
module tlmc_back #(
    parameter int COST_BITS = tlmc_pkg::COST_BITS_DEFAULT
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_item_empty,
    input  logic [3*COST_BITS+tlmc_pkg::PHASE_BITS:0] i_item,
    output logic                                      o_item_pop,
    input  logic                                      i_res_full,
    output logic                                      o_res_push,
    output logic [tlmc_pkg::ACC_BITS-1:0]             o_res_data
);
    import tlmc_pkg::*;

    localparam int EXT_BITS = ACC_BITS - COST_BITS;

    logic signed [ACC_BITS-1:0] r_best_left, r_best_mid, r_best_right;
    logic signed [ACC_BITS-1:0] n_best_left, n_best_mid, n_best_right;

    logic [PHASE_BITS-1:0]      phase;
    logic                       last;
    logic [COST_BITS-1:0]       c0_raw, c1_raw, c2_raw;
    logic signed [ACC_BITS-1:0] c0, c1, c2;
    logic signed [ACC_BITS-1:0] min_l, min_m, min_r;
    logic signed [ACC_BITS-1:0] sum_l, sum_m, sum_r;
    logic                       take;

    assign {phase, last, c0_raw, c1_raw, c2_raw} = i_item;

    assign c0 = {{EXT_BITS{c0_raw[COST_BITS-1]}}, c0_raw};
    assign c1 = {{EXT_BITS{c1_raw[COST_BITS-1]}}, c1_raw};
    assign c2 = {{EXT_BITS{c2_raw[COST_BITS-1]}}, c2_raw};

    assign take       = !i_item_empty && !i_res_full;
    assign o_item_pop = take;
    assign o_res_push = take && last;

    always_comb begin
        min_l = r_best_mid;
        if (phase != PH_SECOND && r_best_left < r_best_mid) begin
            min_l = r_best_left;
        end
        sum_l = c0 + min_l;

        min_m = min_l;
        if (r_best_right < min_m) begin
            min_m = r_best_right;
        end
        if (sum_l < min_m) begin
            min_m = sum_l;
        end
        sum_m = c1 + min_m;

        min_r = (r_best_right < r_best_mid) ? r_best_right : r_best_mid;
        if (sum_m < min_r) begin
            min_r = sum_m;
        end
        sum_r = c2 + min_r;

        unique case (phase)
            PH_FIRST: begin
                n_best_left  = c0;
                n_best_mid   = c1;
                n_best_right = c1 + c2;
            end
            default: begin
                n_best_left  = sum_l;
                n_best_mid   = sum_m;
                n_best_right = sum_r;
            end
        endcase
    end

    assign o_res_data = n_best_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_left  <= '0;
            r_best_mid   <= '0;
            r_best_right <= '0;
        end else if (take) begin
            r_best_left  <= n_best_left;
            r_best_mid   <= n_best_mid;
            r_best_right <= n_best_right;
        end
    end

endmodule

/* rtl/three_lane_min_cost_path_unit.sv */
// ----------------------------------------------------------------------------
// three_lane_min_cost_path_unit
// Minimum cost path over rows of three vertices, top middle to bottom middle.
//
//   channel   direction  handshake            payload
//   rows      in         i_push / o_full      i_cost_left, i_cost_mid,
//                                             i_cost_right, i_last_row
//   results   out        o_empty / i_pop      o_path_cost
//
// One row per cycle sustained while the result queue has room; the back end retires one row per cycle.
// A last row is registered in the row queue, then its result is computed by the back end and
// registered in the result queue, which shows it on o_path_cost until it is popped.
// Synchronous active-low reset clears queues, row phase and lane costs.
// A full result queue stalls the back end; the row queue then fills and raises o_full.
// ----------------------------------------------------------------------------
`include "three_lane_min_cost_path_unit_defines.svh"

module three_lane_min_cost_path_unit #(
    parameter int COST_BITS       = tlmc_pkg::COST_BITS_DEFAULT,
    parameter int ROW_QUEUE_DEPTH = tlmc_pkg::ROW_QUEUE_DEPTH_DEF,
    parameter int RES_QUEUE_DEPTH = tlmc_pkg::RES_QUEUE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic signed [COST_BITS-1:0]          i_cost_left,
    input  logic signed [COST_BITS-1:0]          i_cost_mid,
    input  logic signed [COST_BITS-1:0]          i_cost_right,
    input  logic                                 i_last_row,
    output logic                                 o_empty,
    input  logic                                 i_pop,
    output logic signed [tlmc_pkg::ACC_BITS-1:0] o_path_cost
);
    import tlmc_pkg::*;

    localparam int ITEM_W = 3 * COST_BITS + PHASE_BITS + 1;

    logic              row_push;
    logic [ITEM_W-1:0] row_item_in;
    logic [ITEM_W-1:0] row_item_out;
    logic              row_empty;
    logic              row_pop;
    t_front_stat       front_stat;

    logic                res_push;
    logic                res_full;
    logic [ACC_BITS-1:0] res_data;
    logic [ACC_BITS-1:0] res_out;

    logic took_last;
    logic took_first;
    logic took_later;

    tlmc_front #(
        .COST_BITS (COST_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_queue_full (o_full),
        .i_cost_left  (i_cost_left),
        .i_cost_mid   (i_cost_mid),
        .i_cost_right (i_cost_right),
        .i_last_row   (i_last_row),
        .o_queue_push (row_push),
        .o_item       (row_item_in),
        .o_stat       (front_stat)
    );

    tlmc_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (ROW_QUEUE_DEPTH)
    ) u_row_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (row_push),
        .i_data  (row_item_in),
        .o_full  (o_full),
        .i_pop   (row_pop),
        .o_data  (row_item_out),
        .o_empty (row_empty)
    );

    tlmc_back #(
        .COST_BITS (COST_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_empty (row_empty),
        .i_item       (row_item_out),
        .o_item_pop   (row_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res_data   (res_data)
    );

    tlmc_queue #(
        .WIDTH (ACC_BITS),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (res_out),
        .o_empty (o_empty)
    );

    assign o_path_cost = res_out;

    assign took_last  = front_stat.accept && front_stat.last;
    assign took_first = front_stat.accept && !front_stat.last && front_stat.phase == PH_FIRST;
    assign took_later = front_stat.accept && !front_stat.last && front_stat.phase != PH_FIRST;

    `TLMC_ASSERT_NOW(a_pop_needs_room, i_clk, i_rst_n, !row_pop || !res_full)
    `TLMC_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, took_last, front_stat.phase == PH_FIRST)
    `TLMC_ASSERT_NEXT(a_first_to_second, i_clk, i_rst_n, took_first, front_stat.phase == PH_SECOND)
    `TLMC_ASSERT_NEXT(a_later_holds, i_clk, i_rst_n, took_later, front_stat.phase == PH_LATER)

endmodule
